FILE: design/rhsc_pkg.sv
// ----------------------------------------------------------------------------
// Rolling hash substring counter: shared definitions
// Widths, command encoding and the base-31 helper used by the front end, the
// command queue and the hash back end.
// ----------------------------------------------------------------------------
package rhsc_pkg;

  localparam int MAX_KEY_LEN = 64;
  localparam int KLEN_W      = $clog2(MAX_KEY_LEN + 1);
  localparam int ADDR_W      = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int HASH_W      = 32;
  localparam int POS_W       = 16;
  localparam int CHAR_W      = 8;
  localparam int OP_W        = 2;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [CHAR_W-1:0]   chr_t;
  typedef logic [HASH_W-1:0]   hash_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [POS_W:0]      posx_t;
  typedef logic [KLEN_W-1:0]   klen_t;
  typedef logic [KLEN_W:0]     klenx_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [Q_AW-1:0]     qptr_t;
  typedef logic [Q_CW-1:0]     qcnt_t;

  // Request operation codes as they arrive on the input channel.
  localparam op_t OP_KEY   = 2'd0;
  localparam op_t OP_TEXT  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  localparam pos_t  POS_MAX  = '1;
  localparam hash_t HASH_ONE = hash_t'(1);

  typedef enum logic [1:0] {
    KIND_KEY,
    KIND_TEXT,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t kind;
    chr_t  chr;
  } cmd_t;

  // Multiply by 31 modulo 2^32 as a shift and a subtract.
  function automatic hash_t mul31(input hash_t x);
    return (x << 5) - x;
  endfunction

endpackage

FILE: design/rhsc_ifs.sv
// ----------------------------------------------------------------------------
// Rolling hash substring counter: channel interfaces
// Valid/ready channels for incoming requests and outgoing match results.
// ----------------------------------------------------------------------------
interface rhsc_in_if;
  logic           valid;
  logic           ready;
  rhsc_pkg::op_t  op;
  rhsc_pkg::chr_t char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink   (input valid, input op, input char_code, output ready);
endinterface

interface rhsc_out_if;
  logic           valid;
  logic           ready;
  logic           match;
  rhsc_pkg::pos_t start_position;
  rhsc_pkg::pos_t match_count;

  modport source (output valid, output match, output start_position, output match_count,
                  input ready);
  modport sink   (input valid, input match, input start_position, input match_count,
                  output ready);
endinterface

FILE: design/rhsc_front.sv
// ----------------------------------------------------------------------------
// Rolling hash substring counter: front end
// Registers each request and decodes its operation code into a command.
// Requests with the unused code are dropped here.
// ----------------------------------------------------------------------------
module rhsc_front (
  input  logic             clk,
  input  logic             rst_n,
  rhsc_in_if.sink          in_chan,
  output logic             fe_valid,
  output rhsc_pkg::cmd_t   fe_cmd,
  input  logic             fe_ready
);

  logic           fe_valid_r;
  logic           fe_valid_nxt;
  rhsc_pkg::cmd_t fe_cmd_r;
  rhsc_pkg::cmd_t fe_cmd_nxt;
  logic           dec_ok;
  logic           load;

  assign in_chan.ready = !fe_valid_r || fe_ready;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    dec_ok          = 1'b1;
    fe_cmd_nxt.chr  = in_chan.char_code;
    fe_cmd_nxt.kind = rhsc_pkg::KIND_TEXT;
    case (in_chan.op)
      rhsc_pkg::OP_KEY:   fe_cmd_nxt.kind = rhsc_pkg::KIND_KEY;
      rhsc_pkg::OP_TEXT:  fe_cmd_nxt.kind = rhsc_pkg::KIND_TEXT;
      rhsc_pkg::OP_CLEAR: fe_cmd_nxt.kind = rhsc_pkg::KIND_CLEAR;
      default:            dec_ok = 1'b0;
    endcase
  end

  always_comb begin
    if (load) begin
      fe_valid_nxt = dec_ok;
    end else begin
      fe_valid_nxt = fe_valid_r && !fe_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else begin
      fe_valid_r <= fe_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fe_cmd_r <= fe_cmd_nxt;
    end
  end

  assign fe_valid = fe_valid_r;
  assign fe_cmd   = fe_cmd_r;

endmodule

FILE: design/rhsc_queue.sv
// ----------------------------------------------------------------------------
// Rolling hash substring counter: command queue
// Small FIFO between the front end and the hash back end so that either side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module rhsc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  rhsc_pkg::cmd_t   in_cmd,
  output logic             in_ready,
  output logic             out_valid,
  output rhsc_pkg::cmd_t   out_cmd,
  input  logic             out_ready
);

  rhsc_pkg::cmd_t  q_mem [rhsc_pkg::Q_DEPTH];
  rhsc_pkg::qptr_t wp_r;
  rhsc_pkg::qptr_t wp_nxt;
  rhsc_pkg::qptr_t rp_r;
  rhsc_pkg::qptr_t rp_nxt;
  rhsc_pkg::qcnt_t cnt_r;
  rhsc_pkg::qcnt_t cnt_nxt;
  logic            push;
  logic            pop;

  assign in_ready  = cnt_r != rhsc_pkg::qcnt_t'(rhsc_pkg::Q_DEPTH);
  assign out_valid = cnt_r != '0;
  assign out_cmd   = q_mem[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // The depth is a power of two, so the pointers wrap on their own.
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= in_cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rhsc_pkg::qcnt_t'(rhsc_pkg::Q_DEPTH))
    else $error("queue fill count beyond depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not follow a lone write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != rhsc_pkg::qcnt_t'(rhsc_pkg::Q_DEPTH) |->
      rhsc_pkg::qptr_t'(wp_r - rp_r) == rhsc_pkg::qptr_t'(cnt_r))
    else $error("queue pointers disagree with fill count");

endmodule

FILE: design/rhsc_back.sv
// ----------------------------------------------------------------------------
// Rolling hash substring counter: hash back end
// Three-stage pipeline with an output register. Hashes are kept with absolute
// powers of 31 (character at text index j weighs 31^j), and the window sum is
// compared against the key hash scaled by 31^(window start). Since 31 is odd
// this equals comparing the start-normalized window hash with the key hash.
// Stage 1 updates the key, writes the character ring and reads the leaving
// character; stage 2 weighs the leaving character and scales the key hash;
// stage 3 rolls the window sum, compares and counts.
// ----------------------------------------------------------------------------
module rhsc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  rhsc_pkg::cmd_t   q_cmd,
  output logic             q_ready,
  rhsc_out_if.source       out_chan
);

  typedef struct packed {
    logic            valid;
    logic            text;
    logic            clr;
    logic            leave;
    logic            elig;
    rhsc_pkg::pos_t  start;
    rhsc_pkg::hash_t cp;
    rhsc_pkg::hash_t khash;
  } s1_t;

  typedef struct packed {
    logic            valid;
    logic            text;
    logic            clr;
    logic            elig;
    rhsc_pkg::pos_t  start;
    rhsc_pkg::hash_t cp;
    rhsc_pkg::hash_t lp;
  } s2_t;

  logic adv;

  // Stage 1 state
  rhsc_pkg::klen_t  klen_r, klen_nxt;
  rhsc_pkg::hash_t  khash_r, khash_nxt;
  rhsc_pkg::hash_t  kpow_r, kpow_nxt;
  rhsc_pkg::pos_t   idx_r, idx_nxt;
  rhsc_pkg::hash_t  pw_r, pw_nxt;
  rhsc_pkg::addr_t  wr_r, wr_nxt;
  rhsc_pkg::chr_t   ring_mem [rhsc_pkg::MAX_KEY_LEN];
  rhsc_pkg::chr_t   lv_chr_r;
  rhsc_pkg::addr_t  raddr;
  rhsc_pkg::klenx_t wr_ext;
  rhsc_pkg::klenx_t kl_ext;
  rhsc_pkg::posx_t  idx_inc;
  logic             text_go;
  s1_t              s1_r, s1_nxt;

  // Stage 2 state
  rhsc_pkg::hash_t  pl_r, pl_nxt;
  rhsc_pkg::hash_t  kp_r, kp_nxt;
  rhsc_pkg::hash_t  lv_ext;
  s2_t              s2_r, s2_nxt;

  // Stage 3 state
  rhsc_pkg::hash_t  w_r, w_nxt;
  rhsc_pkg::pos_t   hit_r, hit_nxt;
  rhsc_pkg::hash_t  w_sum;
  logic             hit;

  logic             out_valid_r;
  logic             match_r;
  rhsc_pkg::pos_t   start_r;
  rhsc_pkg::pos_t   cnt_r;

  // The whole pipeline moves together whenever the output register frees up.
  assign adv     = !out_valid_r || out_chan.ready;
  assign q_ready = adv;
  assign text_go = adv && q_valid && (q_cmd.kind == rhsc_pkg::KIND_TEXT);

  // Leaving character sits klen characters behind the write pointer.
  always_comb begin
    wr_ext = rhsc_pkg::klenx_t'(wr_r);
    kl_ext = rhsc_pkg::klenx_t'(klen_r);
    if (wr_ext >= kl_ext) begin
      raddr = rhsc_pkg::addr_t'(wr_ext - kl_ext);
    end else begin
      raddr = rhsc_pkg::addr_t'(wr_ext + rhsc_pkg::klenx_t'(rhsc_pkg::MAX_KEY_LEN) - kl_ext);
    end
  end

  always_comb begin
    klen_nxt  = klen_r;
    khash_nxt = khash_r;
    kpow_nxt  = kpow_r;
    idx_nxt   = idx_r;
    pw_nxt    = pw_r;
    wr_nxt    = wr_r;
    s1_nxt    = '0;
    idx_inc   = rhsc_pkg::posx_t'(idx_r) + 1'b1;
    if (q_valid) begin
      case (q_cmd.kind)
        rhsc_pkg::KIND_KEY: begin
          // Key characters past the maximum length are dropped without effect.
          if (klen_r < rhsc_pkg::klen_t'(rhsc_pkg::MAX_KEY_LEN)) begin
            khash_nxt    = khash_r + rhsc_pkg::hash_t'(rhsc_pkg::hash_t'(q_cmd.chr) * kpow_r);
            kpow_nxt     = rhsc_pkg::mul31(kpow_r);
            klen_nxt     = klen_r + 1'b1;
            idx_nxt      = '0;
            pw_nxt       = rhsc_pkg::HASH_ONE;
            s1_nxt.valid = 1'b1;
            s1_nxt.clr   = 1'b1;
            s1_nxt.khash = khash_nxt;
          end
        end
        rhsc_pkg::KIND_CLEAR: begin
          klen_nxt     = '0;
          khash_nxt    = '0;
          kpow_nxt     = rhsc_pkg::HASH_ONE;
          idx_nxt      = '0;
          pw_nxt       = rhsc_pkg::HASH_ONE;
          s1_nxt.valid = 1'b1;
          s1_nxt.clr   = 1'b1;
        end
        rhsc_pkg::KIND_TEXT: begin
          s1_nxt.valid = 1'b1;
          s1_nxt.text  = 1'b1;
          s1_nxt.leave = (klen_r != '0) && (idx_r >= rhsc_pkg::pos_t'(klen_r));
          s1_nxt.elig  = (klen_r != '0) && (idx_inc >= rhsc_pkg::posx_t'(klen_r));
          s1_nxt.start = rhsc_pkg::pos_t'(idx_inc - rhsc_pkg::posx_t'(klen_r));
          s1_nxt.cp    = rhsc_pkg::hash_t'(rhsc_pkg::hash_t'(q_cmd.chr) * pw_r);
          pw_nxt       = rhsc_pkg::mul31(pw_r);
          if (idx_r != rhsc_pkg::POS_MAX) begin
            idx_nxt = idx_r + 1'b1;
          end
          if (wr_r == rhsc_pkg::addr_t'(rhsc_pkg::MAX_KEY_LEN - 1)) begin
            wr_nxt = '0;
          end else begin
            wr_nxt = wr_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Character ring: read before write, so a full-length key sees the oldest entry.
  always_ff @(posedge clk) begin
    if (text_go) begin
      ring_mem[wr_r] <= q_cmd.chr;
      lv_chr_r       <= ring_mem[raddr];
    end
  end

  always_comb begin
    pl_nxt = pl_r;
    kp_nxt = kp_r;
    lv_ext = s1_r.leave ? rhsc_pkg::hash_t'(lv_chr_r) : '0;
    s2_nxt.valid = s1_r.valid;
    s2_nxt.text  = s1_r.text;
    s2_nxt.clr   = s1_r.clr;
    s2_nxt.elig  = s1_r.elig;
    s2_nxt.start = s1_r.start;
    s2_nxt.cp    = s1_r.cp;
    s2_nxt.lp    = rhsc_pkg::hash_t'(lv_ext * pl_r);
    if (s1_r.valid) begin
      if (s1_r.clr) begin
        pl_nxt = rhsc_pkg::HASH_ONE;
        kp_nxt = s1_r.khash;
      end else if (s1_r.text && s1_r.leave) begin
        pl_nxt = rhsc_pkg::mul31(pl_r);
        kp_nxt = rhsc_pkg::mul31(kp_r);
      end
    end
  end

  always_comb begin
    w_nxt   = w_r;
    hit_nxt = hit_r;
    w_sum   = (w_r - s2_r.lp) + s2_r.cp;
    hit     = s2_r.valid && s2_r.text && s2_r.elig && (w_sum == kp_r);
    if (s2_r.valid) begin
      if (s2_r.clr) begin
        w_nxt   = '0;
        hit_nxt = '0;
      end else if (s2_r.text) begin
        w_nxt = w_sum;
        if (hit && hit_r != rhsc_pkg::POS_MAX) begin
          hit_nxt = hit_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r      <= '0;
      khash_r     <= '0;
      kpow_r      <= rhsc_pkg::HASH_ONE;
      idx_r       <= '0;
      pw_r        <= rhsc_pkg::HASH_ONE;
      wr_r        <= '0;
      s1_r        <= '0;
      pl_r        <= rhsc_pkg::HASH_ONE;
      kp_r        <= '0;
      s2_r        <= '0;
      w_r         <= '0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      klen_r      <= klen_nxt;
      khash_r     <= khash_nxt;
      kpow_r      <= kpow_nxt;
      idx_r       <= idx_nxt;
      pw_r        <= pw_nxt;
      wr_r        <= wr_nxt;
      s1_r        <= s1_nxt;
      pl_r        <= pl_nxt;
      kp_r        <= kp_nxt;
      s2_r        <= s2_nxt;
      w_r         <= w_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= s2_r.valid && s2_r.text;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      match_r <= hit;
      start_r <= hit ? s2_r.start : '0;
      cnt_r   <= hit_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.match          = match_r;
  assign out_chan.start_position = start_r;
  assign out_chan.match_count    = cnt_r;

  a_klen_max: assert property (@(posedge clk) disable iff (!rst_n)
    klen_r <= rhsc_pkg::klen_t'(rhsc_pkg::MAX_KEY_LEN))
    else $error("key length beyond maximum");

  a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && match_r |-> cnt_r != '0)
    else $error("match reported with zero match count");

  a_clear_text: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s2_r.valid && s2_r.clr |=> w_r == '0 && hit_r == '0)
    else $error("text state not cleared after key change");

  a_no_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
    adv && q_valid && q_cmd.kind == rhsc_pkg::KIND_TEXT && klen_r == '0 |=> !s1_r.elig)
    else $error("empty key marked as able to match");

endmodule

FILE: design/rolling_hash_substring_counter_top.sv
// ----------------------------------------------------------------------------
// Rolling hash substring counter: top level
// Base-31 rolling-hash substring matcher. Key characters build the key hash;
// each text character returns whether the window ending there hashes equal
// to the key, the window start and the running match count.
//
//   Channel    Dir  Handshake     Payload
//   in_chan    in   valid/ready   op, char_code
//   out_chan   out  valid/ready   match, start_position, match_count
//
// One request is taken per clock cycle; every stage of the hash pipeline
// holds a different request, and the character ring is read and written in
// the same cycle, so only the output side can slow the pipeline down.
// A text character's result passes the front-end register, the queue, stage 1, stage 2 and
// the output register; key and clear requests produce no result.
// Reset (rst_n low, synchronous) empties the key and text state; the character
// ring needs no clearing since only entries written in the current text are read.
// A stalled output holds the back end; the queue keeps accepting until it fills.
// ----------------------------------------------------------------------------
module rolling_hash_substring_counter_top (
  input  logic        clk,
  input  logic        rst_n,
  rhsc_in_if.sink     in_chan,
  rhsc_out_if.source  out_chan
);

  logic           fe_valid;
  rhsc_pkg::cmd_t fe_cmd;
  logic           fe_ready;
  logic           q_valid;
  rhsc_pkg::cmd_t q_cmd;
  logic           q_ready;

  rhsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .fe_valid (fe_valid),
    .fe_cmd   (fe_cmd),
    .fe_ready (fe_ready)
  );

  rhsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fe_valid),
    .in_cmd    (fe_cmd),
    .in_ready  (fe_ready),
    .out_valid (q_valid),
    .out_cmd   (q_cmd),
    .out_ready (q_ready)
  );

  rhsc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_ready  (q_ready),
    .out_chan (out_chan)
  );

endmodule

FILE: sim/rhsc_match_checker.sv
// ----------------------------------------------------------------------------
// Rolling hash substring counter: match checker
// Watches both channels of the block, keeps its own copy of the key and
// window state, works out the result of every accepted text request and
// compares each returned result with the oldest one still owed.
// ----------------------------------------------------------------------------
module rhsc_match_checker (
  input  logic clk,
  input  logic rst_n,
  rhsc_in_if   in_mon,
  rhsc_out_if  out_mon,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import rhsc_pkg::*;

  localparam hash_t HASH_BASE_31 = 32'd31;
  // Inverse of 31 modulo 2^32, used to drop one power when the window rolls.
  localparam hash_t HASH_INV_31  = 32'hBDEF7BDF;
  localparam int    PRINT_LIMIT  = 100;

  typedef struct packed {
    logic match;
    pos_t start_position;
    pos_t match_count;
  } match_res_t;

  hash_t       key_hash;
  int unsigned key_len;
  hash_t       top_power;
  chr_t        window_q [MAX_KEY_LEN];
  hash_t       win_hash;
  int unsigned text_pos;
  int unsigned hit_total;
  match_res_t  owed_results[$];

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  task automatic clear_text();
    win_hash  = '0;
    text_pos  = 0;
    hit_total = 0;
  endtask

  task automatic clear_all();
    key_hash  = '0;
    key_len   = 0;
    top_power = HASH_ONE;
    for (int i = 0; i < MAX_KEY_LEN; i++) window_q[i] = '0;
    clear_text();
  endtask

  // Updates the state for one request and queues the result a text request owes.
  task automatic predict_request(op_t op, chr_t c);
    match_res_t res;
    hash_t      leaving;
    res     = '0;
    leaving = '0;
    case (op)
      OP_CLEAR: begin
        clear_all();
      end
      OP_KEY: begin
        if (key_len < MAX_KEY_LEN) begin
          if (key_len > 0) top_power = top_power * HASH_BASE_31;
          key_hash = key_hash + hash_t'(c) * top_power;
          key_len++;
          clear_text();
        end
      end
      OP_TEXT: begin
        if (key_len > 0) begin
          if (text_pos >= key_len) leaving = hash_t'(window_q[key_len-1]);
          win_hash = (win_hash - leaving) * HASH_INV_31 + hash_t'(c) * top_power;
          for (int i = MAX_KEY_LEN - 1; i > 0; i--) window_q[i] = window_q[i-1];
          window_q[0] = c;
          if (text_pos + 1 >= key_len && win_hash == key_hash) begin
            res.match          = 1'b1;
            res.start_position = pos_t'(text_pos - (key_len - 1));
            if (hit_total < POS_MAX) hit_total++;
          end
        end
        if (text_pos < POS_MAX) text_pos++;
        res.match_count = pos_t'(hit_total);
        owed_results = {owed_results, res};
      end
      default: ;
    endcase
  endtask

  // Every failure is counted; printing stops after a while to keep logs short.
  task automatic report_mismatch(string msg);
    if (errors < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    match_res_t want;
    if (!rst_n) begin
      clear_all();
      owed_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result returned with no text request outstanding");
        end else begin
          want = owed_results.pop_front();
          if (out_mon.match !== want.match)
            report_mismatch($sformatf("match: expected %0d, got %0d",
                                      want.match, out_mon.match));
          if (out_mon.start_position !== want.start_position)
            report_mismatch($sformatf("start_position: expected %0d, got %0d",
                                      want.start_position, out_mon.start_position));
          if (out_mon.match_count !== want.match_count)
            report_mismatch($sformatf("match_count: expected %0d, got %0d",
                                      want.match_count, out_mon.match_count));
        end
      end
      if (in_mon.valid && in_mon.ready) predict_request(in_mon.op, in_mon.char_code);
    end
    outstanding <= owed_results.size();
  end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Rolling hash substring counter: testbench top
// Drives key, text, clear and unused requests into the block, with random
// gaps on both channels, a long output stall and drain pauses between the
// idling phases. The checker beside the block does the prediction; this
// module makes stimulus and decides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rhsc_pkg::*;

  localparam op_t OP_UNUSED   = 2'd3;
  localparam int  QUIET_LIMIT = 4000;
  localparam int  HOLD_CYCLES = 300;
  localparam int  PHASE_ITEMS = 550;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   results_due;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_len;
  int   sent;
  int   quiet_cycles;

  rhsc_in_if  in_chan ();
  rhsc_out_if out_chan ();

  rolling_hash_substring_counter_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rhsc_match_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .errors      (mismatches),
    .outstanding (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random back-pressure, plus a long hold-off when one is asked for.
  initial begin
    int stall_left;
    stall_left     = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        stall_left = hold_len;
        hold_len   = 0;
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Nothing accepted on either channel for too long means the block is stuck.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_req(op_t op, chr_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid     <= 1'b0;
      in_chan.op        <= op_t'($urandom);
      in_chan.char_code <= chr_t'($urandom);
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.op        <= op;
    in_chan.char_code <= c;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    if (op != OP_UNUSED) sent++;
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic chr_t pick_char(int base, int span);
    return chr_t'(base + $urandom_range(0, span));
  endfunction

  // An optional clear, a key and a text that often holds copies of the key, with a
  // sprinkling of unused codes, mid-text key characters and clears.
  task automatic run_text_session();
    int   klen;
    int   tlen;
    int   span;
    int   base;
    int   roll;
    int   done;
    chr_t ch;
    chr_t key_chars[$];
    span = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : 255;
    base = $urandom_range(0, 255 - span);
    if ($urandom_range(0, 99) < 80) send_req(OP_CLEAR, chr_t'($urandom));
    roll = $urandom_range(0, 99);
    if (roll < 80)      klen = $urandom_range(1, 6);
    else if (roll < 95) klen = $urandom_range(7, MAX_KEY_LEN);
    else                klen = $urandom_range(MAX_KEY_LEN + 1, MAX_KEY_LEN + 6);
    for (int k = 0; k < klen; k++) begin
      ch = pick_char(base, span);
      if (key_chars.size() < MAX_KEY_LEN) key_chars = {key_chars, ch};
      send_req(OP_KEY, ch);
    end
    tlen = $urandom_range(8, 40) + ((klen > 8) ? klen : 0);
    done = 0;
    while (done < tlen) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        foreach (key_chars[k]) send_req(OP_TEXT, key_chars[k]);
        done += key_chars.size();
      end else if (roll < 28) begin
        send_req(OP_UNUSED, chr_t'($urandom));
      end else if (roll < 30) begin
        send_req(OP_KEY, pick_char(base, span));
      end else if (roll < 31) begin
        send_req(OP_CLEAR, chr_t'($urandom));
      end else begin
        send_req(OP_TEXT, pick_char(base, span));
        done++;
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.op        = OP_KEY;
    in_chan.char_code = '0;
    send_idle_pct     = 14;
    recv_idle_pct     = 69;
    hold_len          = 0;
    sent              = 0;
    quiet_cycles      = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty key, unused code, byte extremes, a key restarted
    // mid-text, a window that is not yet full, and text after a clear.
    send_req(OP_TEXT, 8'h41);
    send_req(OP_UNUSED, 8'hFF);
    send_req(OP_KEY, 8'h00);
    send_req(OP_KEY, 8'hFF);
    send_req(OP_TEXT, 8'h00);
    send_req(OP_TEXT, 8'hFF);
    send_req(OP_TEXT, 8'h00);
    send_req(OP_TEXT, 8'hFF);
    send_req(OP_KEY, 8'h12);
    send_req(OP_TEXT, 8'h00);
    send_req(OP_TEXT, 8'hFF);
    send_req(OP_TEXT, 8'h12);
    send_req(OP_TEXT, 8'h80);
    send_req(OP_CLEAR, 8'hA5);
    send_req(OP_TEXT, 8'h7F);
    send_req(OP_KEY, 8'h55);
    send_req(OP_TEXT, 8'h55);
    send_req(OP_TEXT, 8'hAA);

    // The result side stops for a long stretch while requests keep coming.
    hold_len = HOLD_CYCLES;
    while (sent < PHASE_ITEMS) run_text_session();

    drain_results();
    send_idle_pct = 69;
    recv_idle_pct = 14;
    while (sent < 2 * PHASE_ITEMS) run_text_session();

    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sent < 3 * PHASE_ITEMS) run_text_session();

    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
